// ----- src/longest_queue_first_matcher_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the longest queue first matcher.
// Checks that hold in the same cycle and checks that hold in the next cycle.
// ---------------------------------------------------------------------------
`ifndef LONGEST_QUEUE_FIRST_MATCHER_DEFINES_SVH
`define LONGEST_QUEUE_FIRST_MATCHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LQFM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lqfm same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LQFM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lqfm next-cycle check failed");

`endif

// ----- src/lqfm_pkg.sv -----
// ---------------------------------------------------------------------------
// lqfm_pkg
// Shared constants, controller states and the command and status words
// that join the controller and the datapath of the matcher.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lqfm_pkg;

  localparam int N_PORTS_DEF    = 8;
  localparam int QUEUE_BITS_DEF = 16;

  localparam logic [15:0] LFSR_SEED = 16'd44257;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NUM_ITERATIONS = 2'd0;
  localparam logic [1:0] CFG_INPUTS_IN_USE  = 2'd1;
  localparam logic [1:0] CFG_OUTPUTS_IN_USE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_ROUND,
    S_OUTER,
    S_READ,
    S_CMP,
    S_PICK,
    S_DIV,
    S_FIND,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic start;
    logic round;
    logic next_phase;
    logic outer_skip;
    logic outer_begin;
    logic rd;
    logic cmp;
    logic pick;
    logic div;
    logic find;
    logic commit;
    logic iter_next;
    logic emit_init;
    logic emit_next;
    logic clear_store;
    logic emit_valid;
    logic busy;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic iter_zero;
    logic iter_last;
    logic accept_phase;
    logic outer_end;
    logic outer_busy;
    logic scan_last;
    logic best_zero;
    logic cnt_multi;
    logic div_last;
    logic find_hit;
    logic emit_last;
  } status_t;

endpackage

`default_nettype wire

// ----- src/lqfm_ctrl.sv -----
// ---------------------------------------------------------------------------
// lqfm_ctrl
// Sequencer of the matcher: loading, grant and accept scans, tie breaking
// and result delivery.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lqfm_ctrl
  import lqfm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    last_entry,
  input  wire logic    out_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && last_entry) state_next = S_START;
      end
      S_START: begin
        state_next = status.iter_zero ? S_EMIT : S_ROUND;
      end
      S_ROUND: begin
        state_next = S_OUTER;
      end
      S_OUTER: begin
        if (status.outer_end) begin
          if (!status.accept_phase) state_next = S_OUTER;
          else if (status.iter_last) state_next = S_EMIT;
          else state_next = S_ROUND;
        end else if (!status.outer_busy) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (status.scan_last) state_next = S_PICK;
        else state_next = S_READ;
      end
      S_PICK: begin
        if (status.best_zero) state_next = S_OUTER;
        else if (status.cnt_multi) state_next = S_DIV;
        else state_next = S_FIND;
      end
      S_DIV: begin
        if (status.div_last) state_next = S_FIND;
      end
      S_FIND: begin
        if (status.find_hit) state_next = S_OUTER;
      end
      S_EMIT: begin
        if (!out_stall && status.emit_last) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
      end
      S_START: begin
        cmd.busy      = 1'b1;
        cmd.start     = 1'b1;
        cmd.emit_init = status.iter_zero;
      end
      S_ROUND: begin
        cmd.busy  = 1'b1;
        cmd.round = 1'b1;
      end
      S_OUTER: begin
        cmd.busy = 1'b1;
        if (status.outer_end) begin
          if (!status.accept_phase) cmd.next_phase = 1'b1;
          else if (status.iter_last) cmd.emit_init = 1'b1;
          else cmd.iter_next = 1'b1;
        end else if (status.outer_busy) begin
          cmd.outer_skip = 1'b1;
        end else begin
          cmd.outer_begin = 1'b1;
        end
      end
      S_READ: begin
        cmd.busy = 1'b1;
        cmd.rd   = 1'b1;
      end
      S_CMP: begin
        cmd.busy = 1'b1;
        cmd.cmp  = 1'b1;
      end
      S_PICK: begin
        cmd.busy = 1'b1;
        if (status.best_zero) cmd.outer_skip = 1'b1;
        else cmd.pick = 1'b1;
      end
      S_DIV: begin
        cmd.busy = 1'b1;
        cmd.div  = 1'b1;
      end
      S_FIND: begin
        cmd.busy   = 1'b1;
        cmd.find   = 1'b1;
        cmd.commit = status.find_hit;
      end
      S_EMIT: begin
        cmd.busy        = 1'b1;
        cmd.emit_valid  = 1'b1;
        cmd.emit_next   = !out_stall;
        cmd.clear_store = !out_stall && status.emit_last;
      end
      default: begin
        cmd.busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/lqfm_datapath.sv -----
// ---------------------------------------------------------------------------
// lqfm_datapath
// Occupancy store, match state, scan counters, candidate tracking,
// tie-break LFSR with a bit-serial remainder unit, and result fields.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lqfm_datapath
  import lqfm_pkg::*;
#(
  parameter int N_PORTS    = N_PORTS_DEF,
  parameter int QUEUE_BITS = QUEUE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output status_t          status,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_data,
  input  wire logic [2:0]  src_port,
  input  wire logic [2:0]  dst_port,
  input  wire logic [15:0] occupancy,
  output logic [2:0]       out_port,
  output logic [2:0]       granted_in,
  output logic             has_match,
  output logic             end_of_schedule
);

  localparam int DEPTH = N_PORTS * N_PORTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(N_PORTS);
  localparam int CW    = $clog2(N_PORTS + 1);
  localparam int QW    = QUEUE_BITS;

  // Configuration registers.
  logic [4:0] num_iterations;
  logic [3:0] inputs_in_use;
  logic [3:0] outputs_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_iterations <= 5'd1;
      inputs_in_use  <= 4'd8;
      outputs_in_use <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_ITERATIONS: num_iterations <= cfg_data;
        CFG_INPUTS_IN_USE:  inputs_in_use  <= cfg_data[3:0];
        CFG_OUTPUTS_IN_USE: outputs_in_use <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Port counts saturated to one through N_PORTS.
  logic [CW-1:0] ni;
  logic [CW-1:0] no;

  always_comb begin
    if (inputs_in_use == 4'd0) ni = CW'(1);
    else if (32'(inputs_in_use) > N_PORTS) ni = CW'(N_PORTS);
    else ni = CW'(inputs_in_use);
    if (outputs_in_use == 4'd0) no = CW'(1);
    else if (32'(outputs_in_use) > N_PORTS) no = CW'(N_PORTS);
    else no = CW'(outputs_in_use);
  end

  // Scan and schedule registers.
  logic          accept_phase;
  logic [CW-1:0] outer;
  logic [CW-1:0] scan;
  logic [4:0]    iter;
  logic [QW-1:0] best;
  logic [CW-1:0] cnt;
  logic [N_PORTS-1:0] mask;
  logic [15:0]   lfsr;
  logic [CW-1:0] rem;
  logic [3:0]    dstep;
  logic [PW-1:0] find;
  logic [CW-1:0] emit_idx;

  // Match state: one valid bit and one port per entry.
  logic [N_PORTS-1:0] in_matched;
  logic [N_PORTS-1:0] out_matched;
  logic [PW-1:0]      out_match_to [N_PORTS];
  logic [N_PORTS-1:0] grant_ok;
  logic [PW-1:0]      grant_to [N_PORTS];

  // Occupancy store with a presence bit per entry; absent entries read zero.
  logic [QW-1:0]    store [DEPTH];
  logic [DEPTH-1:0] present;
  logic [QW-1:0]    rd_data;
  logic             rd_hit;
  logic             wr_ok;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic [CW-1:0]    row;
  logic [CW-1:0]    col;

  assign wr_ok = (32'(src_port) < N_PORTS) && (32'(dst_port) < N_PORTS);
  assign waddr = AW'(AW'(src_port) * AW'(N_PORTS) + AW'(dst_port));
  assign row   = accept_phase ? outer : scan;
  assign col   = accept_phase ? scan : outer;
  assign raddr = AW'(AW'(row) * AW'(N_PORTS) + AW'(col));

  always_ff @(posedge clk) begin
    if (cmd.load && wr_ok) store[waddr] <= QW'(occupancy);
    if (cmd.rd) begin
      rd_data <= store[raddr];
      rd_hit  <= present[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_store) begin
      present <= '0;
    end else if (cmd.load && wr_ok) begin
      present[waddr] <= 1'b1;
    end
  end

  // Candidate test for the element under the scan.
  logic [QW-1:0] q;
  logic          cand_en;
  logic [15:0]   lfsr_step;
  logic [CW:0]   div_trial;

  assign q = rd_hit ? rd_data : '0;
  assign cand_en = accept_phase
                 ? (grant_ok[scan[PW-1:0]] && (grant_to[scan[PW-1:0]] == outer[PW-1:0]))
                 : !in_matched[scan[PW-1:0]];
  assign lfsr_step = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : 16'h0000);
  assign div_trial = {rem, lfsr[4'd15 - dstep]};

  // Control registers of the scan and the tie break.
  always_ff @(posedge clk) begin
    if (rst) begin
      accept_phase <= 1'b0;
      outer        <= '0;
      scan         <= '0;
      iter         <= '0;
      lfsr         <= LFSR_SEED;
      in_matched   <= '0;
      out_matched  <= '0;
      grant_ok     <= '0;
      emit_idx     <= '0;
    end else begin
      if (cmd.start) begin
        iter        <= '0;
        in_matched  <= '0;
        out_matched <= '0;
        grant_ok    <= '0;
      end
      if (cmd.round) begin
        grant_ok     <= '0;
        outer        <= '0;
        accept_phase <= 1'b0;
      end
      if (cmd.next_phase) begin
        outer        <= '0;
        accept_phase <= 1'b1;
      end
      if (cmd.outer_skip) outer <= outer + CW'(1);
      if (cmd.outer_begin) scan <= '0;
      if (cmd.cmp) scan <= scan + CW'(1);
      if (cmd.pick && cnt > CW'(1)) lfsr <= lfsr_step;
      if (cmd.commit) begin
        outer <= outer + CW'(1);
        if (accept_phase) begin
          in_matched[outer[PW-1:0]] <= 1'b1;
          out_matched[find]         <= 1'b1;
        end else begin
          grant_ok[outer[PW-1:0]] <= 1'b1;
        end
      end
      if (cmd.iter_next) iter <= iter + 5'd1;
      if (cmd.emit_init) emit_idx <= '0;
      else if (cmd.emit_valid && cmd.emit_next) emit_idx <= emit_idx + CW'(1);
    end
  end

  // Candidate tracking, remainder unit and match ports.
  always_ff @(posedge clk) begin
    if (cmd.outer_begin) begin
      best <= '0;
      cnt  <= '0;
      mask <= '0;
    end
    if (cmd.cmp && cand_en) begin
      if (q > best) begin
        best <= q;
        cnt  <= CW'(1);
        mask <= N_PORTS'(1) << scan[PW-1:0];
      end else if (q == best && best != '0) begin
        cnt <= cnt + CW'(1);
        mask[scan[PW-1:0]] <= 1'b1;
      end
    end
    if (cmd.pick) begin
      rem   <= '0;
      dstep <= '0;
      find  <= '0;
    end
    if (cmd.div) begin
      dstep <= dstep + 4'd1;
      if (div_trial >= {1'b0, cnt}) rem <= CW'(div_trial - {1'b0, cnt});
      else rem <= CW'(div_trial);
    end
    if (cmd.find && !cmd.commit) begin
      find <= find + PW'(1);
      if (mask[find]) rem <= rem - CW'(1);
    end
    if (cmd.commit) begin
      if (accept_phase) out_match_to[find] <= outer[PW-1:0];
      else grant_to[outer[PW-1:0]] <= find;
    end
  end

  // Status back to the controller.
  always_comb begin
    status.iter_zero    = (num_iterations == 5'd0);
    status.iter_last    = (iter == num_iterations - 5'd1);
    status.accept_phase = accept_phase;
    status.outer_end    = accept_phase ? (outer >= ni) : (outer >= no);
    status.outer_busy   = accept_phase ? in_matched[outer[PW-1:0]]
                                       : out_matched[outer[PW-1:0]];
    status.scan_last    = accept_phase ? (scan == no - CW'(1)) : (scan == ni - CW'(1));
    status.best_zero    = (best == '0);
    status.cnt_multi    = (cnt > CW'(1));
    status.div_last     = (dstep == 4'd15);
    status.find_hit     = mask[find] && (rem == '0);
    status.emit_last    = (emit_idx == no - CW'(1));
  end

  // Result fields for the output under delivery.
  assign out_port        = 3'(emit_idx);
  assign has_match       = out_matched[emit_idx[PW-1:0]];
  assign granted_in      = has_match ? 3'(out_match_to[emit_idx[PW-1:0]]) : 3'd0;
  assign end_of_schedule = status.emit_last;

endmodule

`default_nettype wire

// ----- src/longest_queue_first_matcher.sv -----
// ---------------------------------------------------------------------------
// longest_queue_first_matcher
// Iterative longest-queue-first crossbar matcher: a sequencer and a datapath.
// ---------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall) loads one queue occupancy
// word per cycle into the store while in_stall is low. A word with
// last_entry set starts a schedule; in_stall stays high until the schedule
// has been delivered. A schedule takes a start step, then per iteration a
// setup step and a grant and an accept phase that scan the store through
// its single read port, each element read and then compared. Per port a
// phase spends an outer step, the scan and a pick step, plus a search
// when the port has a candidate. Every tie adds a bit-serial remainder.
// The result channel (out_valid, out_stall) then delivers one word per
// active output in port order, one per cycle; a stall holds the current
// word. After the last word the store is cleared at once and loading
// resumes; the match state is cleared when the next schedule starts.
// Reset empties the store, clears all matches, reseeds the tie LFSR and
// loads the default configuration. The configuration port must be written
// only while the block is idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "longest_queue_first_matcher_defines.svh"

module longest_queue_first_matcher
  import lqfm_pkg::*;
#(
  parameter int N_PORTS    = N_PORTS_DEF,
  parameter int QUEUE_BITS = QUEUE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  src_port,
  input  wire logic [2:0]  dst_port,
  input  wire logic [15:0] occupancy,
  input  wire logic        last_entry,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_port,
  output logic [2:0]       granted_in,
  output logic             has_match,
  output logic             end_of_schedule
);

  cmd_t    cmd;
  status_t status;

  lqfm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .last_entry (last_entry),
    .out_stall  (out_stall),
    .status     (status),
    .cmd        (cmd)
  );

  lqfm_datapath #(
    .N_PORTS    (N_PORTS),
    .QUEUE_BITS (QUEUE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .src_port        (src_port),
    .dst_port        (dst_port),
    .occupancy       (occupancy),
    .out_port        (out_port),
    .granted_in      (granted_in),
    .has_match       (has_match),
    .end_of_schedule (end_of_schedule)
  );

  assign in_stall  = cmd.busy;
  assign out_valid = cmd.emit_valid;

  // Loading and delivery never overlap.
  `LQFM_ASSERT_NOW(a_no_overlap, out_valid, in_stall)
  // A last word starts a schedule that blocks further loading.
  `LQFM_ASSERT_NEXT(a_last_blocks, in_valid && !in_stall && last_entry, in_stall)
  // Delivery of the final word returns the block to loading.
  `LQFM_ASSERT_NEXT(a_end_idle, out_valid && !out_stall && end_of_schedule,
                    !out_valid && !in_stall)

endmodule

`default_nettype wire
